>>> src/fpfc_pkg.sv
// Shared constants and types for the factorial prime factor counter.
package fpfc_pkg;

    localparam int N_BITS    = 20;
    localparam int DEPTH     = 1 << N_BITS;
    localparam int IN_W      = ((N_BITS + 7) / 8) * 8;
    localparam int TOTAL_W   = 24;
    localparam int OUT_W     = ((TOTAL_W + 7) / 8) * 8;
    localparam int CNT_W     = $clog2(N_BITS + 1);
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
    localparam logic [N_BITS-1:0]  N_TOP     = {N_BITS{1'b1}};

    typedef struct packed {
        logic              start;
        logic [N_BITS-1:0] dividend;
        logic [N_BITS-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [N_BITS-1:0] quot;
    } t_div_rsp;

    typedef enum logic [8:0] {
        S_CLR  = 9'b000000001,
        S_SRD  = 9'b000000010,
        S_SCHK = 9'b000000100,
        S_MARK = 9'b000001000,
        S_IDLE = 9'b000010000,
        S_PRD  = 9'b000100000,
        S_PCHK = 9'b001000000,
        S_DIV  = 9'b010000000,
        S_FIN  = 9'b100000000
    } t_state;

endpackage

>>> src/factorial_prime_factor_count.sv
// Top level: prime factors of n! with multiplicity, Legendre sum over a sieve.
//
//  channel | direction | fields (lowest bit first)
//  s       | in        | tdata: n_value[N_BITS-1:0], zero pad
//  m       | out       | tdata: factor_total[23:0]
//
// After reset a clearing pass over all 2^N_BITS sieve entries and a sieve
// build that writes one composite mark per multiple of each prime (about 2.9M
// marks at N_BITS=20) run before the first item is taken. Each item then
// scans the sieve for primes up to n through the single RAM port and divides
// by each prime power in the shared divider, adding every quotient.
// A finished result waits in the output register; a stalled output holds
// the next result in the final state.
module factorial_prime_factor_count import fpfc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic [IN_W-1:0]  i_s_tdata,   // n_value
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic [OUT_W-1:0] o_m_tdata    // factor_total
);
    t_state             r_st, n_st;
    logic [N_BITS-1:0]  r_i, n_i;
    logic [N_BITS:0]    r_j, n_j;
    logic [N_BITS:0]    r_p, n_p;
    logic [N_BITS-1:0]  r_n, n_n;
    logic [TOTAL_W-1:0] r_acc, n_acc;
    logic               r_ov, n_ov;
    logic [TOTAL_W-1:0] r_out, n_out;
    logic               w_we;
    logic               w_wdata;
    logic               w_rdata;
    logic [N_BITS-1:0]  w_addr;
    logic [TOTAL_W:0]   w_sum;
    logic [N_BITS:0]    w_pn;
    t_div_req           w_req;
    t_div_rsp           w_rsp;

    fpfc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_sieve (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    fpfc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign o_s_tready = (r_st == S_IDLE);
    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = OUT_W'(r_out);

    always_comb begin
        unique case (r_st)
            S_CLR:   w_addr = r_i;
            S_MARK:  w_addr = r_j[N_BITS-1:0];
            S_PRD:   w_addr = r_p[N_BITS-1:0];
            default: w_addr = r_i;
        endcase
        w_we    = (r_st == S_CLR) || (r_st == S_MARK);
        w_wdata = (r_st == S_MARK);
        w_sum   = {1'b0, r_acc} + (TOTAL_W + 1)'(w_rsp.quot);
        w_pn    = r_p + 1'b1;
    end

    always_comb begin
        n_st  = r_st;
        n_i   = r_i;
        n_j   = r_j;
        n_p   = r_p;
        n_n   = r_n;
        n_acc = r_acc;
        n_ov  = r_ov;
        n_out = r_out;
        w_req = '{start: 1'b0, dividend: r_n, divisor: r_p[N_BITS-1:0]};
        if (r_ov && i_m_tready) begin
            n_ov = 1'b0;
        end
        unique case (r_st)
            S_CLR: begin
                n_i = r_i + 1'b1;
                if (r_i == N_TOP) begin
                    n_i  = N_BITS'(2);
                    n_st = S_SRD;
                end
            end
            S_SRD: n_st = S_SCHK;
            S_SCHK: begin
                n_j = {1'b0, r_i} + {1'b0, r_i};
                if (!w_rdata && !n_j[N_BITS]) begin
                    n_st = S_MARK;
                end else if (r_i == N_TOP) begin
                    n_st = S_IDLE;
                end else begin
                    n_i  = r_i + 1'b1;
                    n_st = S_SRD;
                end
            end
            S_MARK: begin
                n_j = r_j + {1'b0, r_i};
                if (n_j[N_BITS]) begin
                    if (r_i == N_TOP) begin
                        n_st = S_IDLE;
                    end else begin
                        n_i  = r_i + 1'b1;
                        n_st = S_SRD;
                    end
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_n   = i_s_tdata[N_BITS-1:0];
                    n_acc = '0;
                    n_p   = (N_BITS + 1)'(2);
                    n_st  = (i_s_tdata[N_BITS-1:0] < N_BITS'(2)) ? S_FIN : S_PRD;
                end
            end
            S_PRD: n_st = S_PCHK;
            S_PCHK: begin
                if (!w_rdata) begin
                    w_req.start = 1'b1;
                    n_st        = S_DIV;
                end else begin
                    n_p  = w_pn;
                    n_st = (w_pn > {1'b0, r_n}) ? S_FIN : S_PRD;
                end
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_acc = (w_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : w_sum[TOTAL_W-1:0];
                    if ({1'b0, w_rsp.quot} >= r_p) begin
                        w_req.start    = 1'b1;
                        w_req.dividend = w_rsp.quot;
                    end else begin
                        n_p  = w_pn;
                        n_st = (w_pn > {1'b0, r_n}) ? S_FIN : S_PRD;
                    end
                end
            end
            S_FIN: begin
                if (!r_ov || i_m_tready) begin
                    n_ov  = 1'b1;
                    n_out = r_acc;
                    n_st  = S_IDLE;
                end
            end
            default: n_st = S_CLR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR;
            r_i  <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_i  <= n_i;
            r_ov <= n_ov;
        end
        r_j   <= n_j;
        r_p   <= n_p;
        r_n   <= n_n;
        r_acc <= n_acc;
        r_out <= n_out;
    end

    a_div_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_st == S_DIV))
        else $error("divider done outside division state");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_st == S_PRD || r_st == S_FIN))
        else $error("accepted item did not start scan");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_st == S_FIN))
        else $error("result raised outside final state");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_PCHK) |-> (r_p <= {1'b0, r_n}))
        else $error("prime scan ran past n");
endmodule

>>> src/fpfc_ram.sv
// Generic single-port RAM with registered read.
module fpfc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/fpfc_div.sv
// Restoring divider, one quotient bit per cycle.
module fpfc_div import fpfc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [N_BITS:0]   r_rem, n_rem;
    logic [N_BITS-1:0] r_q, n_q;
    logic [N_BITS-1:0] r_dvs, n_dvs;
    logic [N_BITS:0]   w_sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_q    = r_q;
        n_dvs  = r_dvs;
        w_sh   = {r_rem[N_BITS-1:0], r_q[N_BITS-1]};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(N_BITS);
            n_rem  = '0;
            n_q    = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_dvs}) begin
                n_rem = w_sh - {1'b0, r_dvs};
                n_q   = {r_q[N_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[N_BITS-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_q   <= n_q;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;
endmodule
